/* rtl/core/ppsa_pkg.sv */
// shared types and constants for the particle pool spawn and age unit
`timescale 1ns / 1ps
package ppsa_pkg;
  localparam int LifeW = 30;
  localparam int AlphaW = 16;
  localparam int PosW = 32;
  localparam logic [AlphaW-1:0] ALPHA_FULL = 16'd32768;
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_KILL = 1'b1;

  typedef struct packed {
    logic [LifeW-1:0] life;
    logic [AlphaW-1:0] alpha;
    logic [PosW-1:0] px;
    logic [PosW-1:0] py;
    logic [PosW-1:0] pz;
    logic [PosW-1:0] pw;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic spawn_en;
    logic age_en;
    logic kill;
  } cell_ctl_t;

  function automatic logic [LifeW-1:0] class_life(input logic [2:0] cls);
    logic [LifeW-1:0] r;
    case (cls)
      3'd0: r = LifeW'(30 * 65536);
      3'd1: r = LifeW'(83 * 65536);
      3'd2: r = LifeW'(135 * 65536);
      3'd3: r = LifeW'(4000 * 65536);
      default: r = LifeW'(8000 * 65536);
    endcase
    return r;
  endfunction
endpackage

/* rtl/core/ppsa_cell.sv */
// one pool slot of the rotating slot ring
`timescale 1ns / 1ps
module ppsa_cell
  import ppsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_ctl_t           ctl,
  input  slot_t               spawn_val,
  input  logic [23:0]         elapsed,
  input  logic [AlphaW-1:0]   fade,
  input  slot_t               prev,
  output slot_t               cur
);
  slot_t s, aged;
  logic [LifeW:0] ldiff;
  always_comb begin
    aged = prev;
    ldiff = {1'b0, prev.life} - {7'd0, elapsed};
    if (prev.life != '0) begin
      aged.life = ldiff[LifeW] || ldiff[LifeW-1:0] == '0 ? '0 : ldiff[LifeW-1:0];
      aged.alpha = prev.alpha > fade ? prev.alpha - fade : '0;
      if (aged.alpha == '0) aged.life = '0;
    end
  end
  // life kept under reset; payload plain
  always_ff @(posedge clk) begin
    if (rst) begin
      s.life <= '0;
    end else if (ctl.kill) begin
      s.life <= '0;
    end else if (ctl.spawn_en) begin
      s <= spawn_val;
    end else if (ctl.shift) begin
      s <= ctl.age_en ? aged : prev;
    end
  end
  assign cur = s;
endmodule

/* rtl/core/particle_pool_spawn_and_age_unit.sv */
// top level: particle pool kept in a rotating ring of slot cells
`timescale 1ns / 1ps
// The pool lives in a ring of POOL_SIZE cells that rotates one slot per cycle
// while it shifts; the slot at the head of the ring is cell 0. An item is
// taken when start is high and busy low. A kill clears every life at the
// accepting edge and gives one empty result on the ports, registered from
// the S_DONE state. An update runs one search pass per spawn: the ring is
// rotated until the head is the slot at search_start, then rotated while
// looking for a dead slot, which is loaded in place at the head; if the whole
// ring is alive it is rotated on to slot 0 and the spawn lands there. Then
// the ring is rotated home to slot 0 and one age pass ages each slot as it
// leaves the head. Live slots are emitted in slot order; each one is held
// until the next live one is found or the pass ends, so the final one carries
// last. Results appear on a one-cycle strobe (valid) and cannot be held off by
// the receiver. An update keeps busy high until the age pass and S_DONE are
// through, and its last result shows in the first cycle with busy low.
module particle_pool_spawn_and_age_unit
  import ppsa_pkg::*;
#(
  parameter int POOL_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                operation,
  input  logic signed [31:0]  emit_x,
  input  logic signed [31:0]  emit_y,
  input  logic signed [31:0]  emit_z,
  input  logic signed [31:0]  emit_w,
  input  logic [23:0]         elapsed,
  input  logic [2:0]          emitter_class,
  output logic                valid,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  pos_z,
  output logic signed [31:0]  pos_w,
  output logic [15:0]         alpha,
  output logic                empty_res,
  output logic                last
);
  localparam int IW = $clog2(POOL_SIZE);
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_ALIGN = 3'd1, S_SEARCH = 3'd2,
                         S_HOME = 3'd3, S_AGE = 3'd4, S_DONE = 3'd5,
                         S_FALL = 3'd6;

  logic [2:0] state;
  logic [6:0] spawn_count, spawns_left;
  logic [IW-1:0] head;          // slot index currently in cell 0
  logic [IW-1:0] search_start;
  logic [CW-1:0] cnt;
  logic [23:0] el;
  logic [2:0] cls;
  logic [31:0] ex, ey, ez, ew;
  logic [AlphaW-1:0] fade;
  slot_t cells [POOL_SIZE];
  slot_t spawn_val;

  // fade = round(elapsed / 400); 24b * reciprocal, then one correction
  logic [24:0] num;
  logic [47:0] prod;
  logic [AlphaW-1:0] q0;
  logic [24:0] rem;
  always_comb begin
    num = {1'b0, elapsed} + 25'd200;
    prod = 48'(num) * 48'd41943;       // floor(2^24/400)
    q0 = AlphaW'(prod >> 24);
    rem = num - 25'(q0) * 25'd400;
  end

  assign busy = state != S_IDLE;
  assign spawn_val = '{life: class_life(cls), alpha: ALPHA_FULL,
                       px: ex, py: ey, pz: ez, pw: ew};

  logic head_dead;
  assign head_dead = cells[0].life == '0;

  // the whole ring rotates together; a spawn holds the ring and loads cell 0,
  // and only the last cell, which receives the ring head, ages what it takes
  cell_ctl_t ctl_rest, ctl_head, ctl_tail;
  logic spawn_now;
  always_comb begin
    spawn_now = state == S_SEARCH && head_dead || state == S_FALL && head == '0;
    ctl_rest.kill = state == S_IDLE && start && operation == OP_KILL;
    ctl_rest.shift = state == S_ALIGN && head != search_start ||
                     state == S_SEARCH && !head_dead && cnt != CW'(POOL_SIZE) ||
                     state == S_FALL && head != '0 ||
                     state == S_HOME && head != '0 || state == S_AGE;
    ctl_rest.spawn_en = 1'b0;
    ctl_rest.age_en = 1'b0;
    ctl_head = ctl_rest;
    ctl_head.spawn_en = spawn_now;
    ctl_tail = ctl_rest;
    ctl_tail.age_en = state == S_AGE;
  end

  genvar g;
  generate
    for (g = 0; g < POOL_SIZE; g++) begin : g_ring
      ppsa_cell u_cell (
        .clk, .rst,
        .ctl(g == 0 ? ctl_head : (g == POOL_SIZE - 1 ? ctl_tail : ctl_rest)),
        .spawn_val, .elapsed(el), .fade,
        .prev(cells[(g + 1) % POOL_SIZE]), .cur(cells[g])
      );
    end
  endgenerate

  // aged value of the head as it leaves cell 0 this cycle
  logic [LifeW:0] hd;
  logic head_live_after;
  logic [AlphaW-1:0] head_alpha;
  slot_t head_emit;
  always_comb begin
    hd = {1'b0, cells[0].life} - {7'd0, el};
    head_alpha = cells[0].alpha > fade ? cells[0].alpha - fade : '0;
    head_live_after = cells[0].life != '0 && !hd[LifeW] &&
                      hd[LifeW-1:0] != '0 && head_alpha != '0;
    head_emit = cells[0];
    head_emit.alpha = head_alpha;
  end

  // pending result held until the next live one or the pass end, to mark the final one
  logic pend;
  slot_t pend_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; spawn_count <= 7'd1; search_start <= '0; head <= '0;
      valid <= 1'b0; pend <= 1'b0;
      cnt <= '0; spawns_left <= '0;
    end else begin
      valid <= state == S_AGE && head_live_after && pend || state == S_DONE;
      if (cfg_we) spawn_count <= cfg_wdata;
      if (ctl_rest.shift) head <= head == IW'(POOL_SIZE - 1) ? '0 : head + 1'b1;
      case (state)
        S_IDLE: if (start) begin
          ex <= emit_x; ey <= emit_y; ez <= emit_z; ew <= emit_w;
          el <= elapsed; cls <= emitter_class;
          fade <= rem >= 25'd400 ? q0 + 1'b1 : q0;
          spawns_left <= spawn_count;
          state <= operation == OP_KILL ? S_DONE : S_ALIGN;
        end
        S_ALIGN: begin
          cnt <= '0;
          if (spawns_left == '0) state <= S_HOME;
          else if (head == search_start) state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (head_dead) begin
            search_start <= head; spawns_left <= spawns_left - 1'b1;
            state <= S_ALIGN;
          end else if (cnt == CW'(POOL_SIZE)) begin
            // whole ring alive: the spawn falls back to slot 0
            state <= S_FALL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FALL: if (head == '0) begin
          search_start <= '0; spawns_left <= spawns_left - 1'b1;
          state <= S_ALIGN;
        end
        S_HOME: begin
          cnt <= '0;
          if (head == '0) state <= S_AGE;
        end
        S_AGE: begin
          cnt <= cnt + 1'b1;
          if (head_live_after) begin
            if (pend) begin
              empty_res <= 1'b0; last <= 1'b0;
              {pos_x, pos_y, pos_z, pos_w} <= {pend_s.px, pend_s.py, pend_s.pz, pend_s.pw};
              alpha <= pend_s.alpha;
            end
            pend <= 1'b1;
            pend_s <= head_emit;
          end
          if (cnt == CW'(POOL_SIZE - 1)) state <= S_DONE;
        end
        S_DONE: begin
          last <= 1'b1; pend <= 1'b0; state <= S_IDLE;
          if (pend) begin
            empty_res <= 1'b0;
            {pos_x, pos_y, pos_z, pos_w} <= {pend_s.px, pend_s.py, pend_s.pz, pend_s.pw};
            alpha <= pend_s.alpha;
          end else begin
            empty_res <= 1'b1;
            {pos_x, pos_y, pos_z, pos_w} <= '0;
            alpha <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/ppsa_checker.sv */
// port-level checks for the particle pool unit, bound to the top level
`timescale 1ns / 1ps
module ppsa_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic valid,
  input logic empty_res,
  input logic last,
  input logic [15:0] alpha
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    valid && empty_res |-> last) else $error("empty result not last");
  a_alpha_nonzero: assert property (@(posedge clk) disable iff (rst)
    valid && !empty_res |-> alpha != 16'd0) else $error("dead particle emitted");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    valid && last |=> !valid) else $error("result after last");
endmodule

bind particle_pool_spawn_and_age_unit ppsa_checker u_ppsa_checker (
  .clk, .rst, .start, .busy, .valid, .empty_res, .last, .alpha
);

/* verif/tb_top.sv */
// self-checking testbench for the particle pool spawn and age unit
`timescale 1ns / 1ps
module tb_top
  import ppsa_pkg::*;
();

  localparam int SLOTS = 64;

  // one emitted particle, or the empty marker
  typedef struct {
    logic [31:0] px, py, pz, pw;
    logic [15:0] alpha;
    logic        empty;
    logic        last;
  } particle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic operation = OP_UPDATE;
  logic signed [31:0] emit_x = '0, emit_y = '0, emit_z = '0, emit_w = '0;
  logic [23:0] elapsed = '0;
  logic [2:0] emitter_class = '0;
  logic valid;
  logic signed [31:0] pos_x, pos_y, pos_z, pos_w;
  logic [15:0] alpha;
  logic empty_res, last;

  // model of the pool as the block should hold it
  logic [29:0] pool_life [SLOTS];
  logic [15:0] pool_alpha [SLOTS];
  logic [31:0] pool_px [SLOTS], pool_py [SLOTS], pool_pz [SLOTS], pool_pw [SLOTS];
  logic [5:0]  next_search;
  logic [6:0]  spawns_per_update;

  particle_t pending_particles [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int kills_sent = 0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  particle_pool_spawn_and_age_unit #(.POOL_SIZE(SLOTS)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .operation(operation), .emit_x(emit_x), .emit_y(emit_y), .emit_z(emit_z),
    .emit_w(emit_w), .elapsed(elapsed), .emitter_class(emitter_class),
    .valid(valid), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .pos_w(pos_w),
    .alpha(alpha), .empty_res(empty_res), .last(last)
  );

  function automatic logic [29:0] lifetime_of(input logic [2:0] cls);
    case (cls)
      3'd0: return 30'(30 << 16);
      3'd1: return 30'(83 << 16);
      3'd2: return 30'(135 << 16);
      3'd3: return 30'(4000 << 16);
      default: return 30'(8000 << 16);
    endcase
  endfunction

  // next-fit search for a dead slot from next_search, wrapping, else slot 0
  function automatic int find_dead_slot();
    int idx;
    for (int n = 0; n < SLOTS; n++) begin
      idx = (int'(next_search) + n) % SLOTS;
      if (pool_life[idx] == '0) return idx;
    end
    return 0;
  endfunction

  // append one expected result at the tail of the queue
  task automatic add_expected(input particle_t p);
    pending_particles.insert(pending_particles.size(), p);
  endtask

  task automatic push_empty();
    particle_t p;
    p = '{default: '0};
    p.empty = 1'b1;
    p.last = 1'b1;
    add_expected(p);
  endtask

  // apply one accepted item to the pool model and queue what it emits
  task automatic predict_pool(input logic op, input logic [31:0] ex, ey, ez, ew,
                              input logic [23:0] el, input logic [2:0] cls);
    int slot;
    int emitted;
    logic [15:0] fade;
    particle_t p;
    emitted = 0;
    if (op == OP_KILL) begin
      // lives cleared, search position kept
      for (int i = 0; i < SLOTS; i++) pool_life[i] = '0;
      push_empty();
      return;
    end
    for (int s = 0; s < spawns_per_update; s++) begin
      slot = find_dead_slot();
      pool_px[slot] = ex;
      pool_py[slot] = ey;
      pool_pz[slot] = ez;
      pool_pw[slot] = ew;
      pool_alpha[slot] = ALPHA_FULL;
      pool_life[slot] = lifetime_of(cls);
      next_search = 6'(slot);
    end
    // elapsed / 400 in Q1.15 LSBs, round half up
    fade = 16'((32'(el) + 200) / 400);
    for (int i = 0; i < SLOTS; i++) begin
      if (pool_life[i] == '0) continue;
      pool_life[i] = (pool_life[i] > 30'(el)) ? pool_life[i] - 30'(el) : '0;
      if (pool_life[i] == '0) continue;
      pool_alpha[i] = (pool_alpha[i] > fade) ? pool_alpha[i] - fade : '0;
      if (pool_alpha[i] == '0) begin
        // faded out: slot dies without being emitted
        pool_life[i] = '0;
        continue;
      end
      p.px = pool_px[i];
      p.py = pool_py[i];
      p.pz = pool_pz[i];
      p.pw = pool_pw[i];
      p.alpha = pool_alpha[i];
      p.empty = 1'b0;
      p.last = 1'b0;
      add_expected(p);
      emitted++;
    end
    if (emitted == 0) push_empty();
    else pending_particles[$].last = 1'b1;
  endtask

  // one item: hold start and the fields until the block takes them;
  // start stays high on return, the caller lowers it when a gap follows
  task automatic send_item(input logic op, input logic [31:0] ex, ey, ez, ew,
                           input logic [23:0] el, input logic [2:0] cls);
    start <= 1'b1;
    operation <= op;
    emit_x <= ex;
    emit_y <= ey;
    emit_z <= ez;
    emit_w <= ew;
    elapsed <= el;
    emitter_class <= cls;
    do @(posedge clk); while (busy);
    predict_pool(op, ex, ey, ez, ew, el, cls);
    items_sent++;
    if (op == OP_KILL) kills_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait until every queued particle has come out and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_particles.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_spawn_count(input logic [6:0] n);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    spawns_per_update = n;
  endtask

  // checker: the receiver cannot stall, every strobe is one result
  always @(posedge clk) begin
    particle_t e;
    if (!rst && valid) begin
      results_seen++;
      if (pending_particles.size() == 0) begin
        $display("%0t: unexpected result x=%h alpha=%h empty=%b last=%b",
                 $time, pos_x, alpha, empty_res, last);
        errors++;
      end else begin
        e = pending_particles.pop_front();
        if (pos_x !== e.px || pos_y !== e.py || pos_z !== e.pz || pos_w !== e.pw) begin
          $display("%0t: position mismatch expected %h %h %h %h actual %h %h %h %h",
                   $time, e.px, e.py, e.pz, e.pw, pos_x, pos_y, pos_z, pos_w);
          errors++;
        end
        if (alpha !== e.alpha) begin
          $display("%0t: alpha mismatch expected %h actual %h", $time, e.alpha, alpha);
          errors++;
        end
        if (empty_res !== e.empty) begin
          $display("%0t: empty_res mismatch expected %b actual %b",
                   $time, e.empty, empty_res);
          errors++;
        end
        if (last !== e.last) begin
          $display("%0t: last mismatch expected %b actual %b", $time, e.last, last);
          errors++;
        end
      end
    end
  end

  function automatic logic [23:0] random_elapsed();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 24'($urandom_range(0, 3000));
    if (pick < 9) return 24'($urandom_range(0, 200000));
    return 24'($urandom);
  endfunction

  // field extremes, all lifetime classes, rounding of the fade, empty pool
  task automatic test_directed();
    logic [31:0] ext [4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    // nothing alive, nothing spawned: empty result
    write_spawn_count(7'd0);
    send_item(OP_UPDATE, 0, 0, 0, 0, 24'd0, 3'd0);
    drain();
    write_spawn_count(7'd1);
    for (int c = 0; c < 8; c++)
      send_item(OP_UPDATE, ext[c % 4], ext[(c + 1) % 4], ext[(c + 2) % 4],
                ext[(c + 3) % 4], 24'd0, 3'(c));
    // fade just below and at the rounding point
    send_item(OP_UPDATE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
              24'd199, 3'd4);
    send_item(OP_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 32'hFFFF_FFFE, 24'd200, 3'd3);
    send_item(OP_UPDATE, 32'h1, 32'h2, 32'h3, 32'h4, 24'd600, 3'd2);
    // fade of a full alpha to zero while life remains
    send_item(OP_UPDATE, 32'h7, 32'h8, 32'h9, 32'hA, 24'd13107200, 3'd3);
    // largest elapsed ages every short life out
    send_item(OP_UPDATE, ext[1], ext[0], ext[3], ext[2], 24'hFF_FFFF, 3'd0);
    pause_sender(3);
    send_item(OP_KILL, 0, 0, 0, 0, 24'd0, 3'd0);
    send_item(OP_UPDATE, 32'hCAFE_0001, 32'h0, 32'h0, 32'h0, 24'h80_0000, 3'd7);
    send_item(OP_KILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              24'hFF_FFFF, 3'd7);
    drain();
  endtask

  // full pool and spawn overflow reusing slot 0
  task automatic test_pool_overflow();
    write_spawn_count(7'd64);
    send_item(OP_UPDATE, 32'h10, 32'h20, 32'h30, 32'h40, 24'd0, 3'd4);
    drain();
    write_spawn_count(7'd127);
    send_item(OP_UPDATE, 32'hDEAD_BEEF, 32'h1, 32'h2, 32'h3, 24'd1000, 3'd1);
    drain();
    write_spawn_count(7'd70);
    send_item(OP_UPDATE, 32'h0BAD_F00D, 32'h4, 32'h5, 32'h6, 24'd50, 3'd5);
    send_item(OP_KILL, 0, 0, 0, 0, 24'd0, 3'd0);
    send_item(OP_UPDATE, 32'h1357_9BDF, 32'h7, 32'h8, 32'h9, 24'd0, 3'd6);
    drain();
    send_item(OP_KILL, 0, 0, 0, 0, 24'd0, 3'd0);
    drain();
  endtask

  // random items in bursts with random gaps, one phase per spawn count
  task automatic test_random_phase(input logic [6:0] count, input int n_items);
    int burst;
    write_spawn_count(count);
    burst = $urandom_range(1, 8);
    for (int k = 0; k < n_items; k++) begin
      send_item(($urandom_range(0, 99) < 8) ? OP_KILL : OP_UPDATE,
                $urandom, $urandom, $urandom, $urandom,
                random_elapsed(), 3'($urandom_range(0, 7)));
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        // some bursts run straight into the next one
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      pool_life[i] = '0;
      pool_alpha[i] = '0;
      pool_px[i] = '0;
      pool_py[i] = '0;
      pool_pz[i] = '0;
      pool_pw[i] = '0;
    end
    next_search = '0;
    spawns_per_update = 7'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_pool_overflow();
    test_random_phase(7'd1, 60);
    test_random_phase(7'd2, 60);
    test_random_phase(7'd0, 25);
    test_random_phase(7'd3, 60);
    test_random_phase(7'd64, 6);
    test_random_phase(7'd5, 50);
    test_random_phase(7'd127, 4);
    test_random_phase(7'd1, 20);

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d items (%0d kills) and %0d results", items_sent, kills_sent,
             results_seen);
    $display("spawn counts 0 to 127, every lifetime class, fade and overflow cases");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // guard against a hung block
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending_particles.size());
    $display("tb_top: errors");
    $finish;
  end
endmodule
